[rtl/core/chd_pkg.sv]
// Package: constants, entry type and state codes for the context Huffman decoder.
`timescale 1ns / 1ps
package chd_pkg;
    localparam int unsigned MAX_LEN_DEF     = 24;
    localparam int unsigned GEN_ENTRIES_DEF = 128;
    localparam int unsigned CONTEXTS_DEF    = 128;
    localparam int unsigned CTX_ENTRIES_DEF = 32;
    localparam int unsigned SYM_W           = 7;
    localparam int unsigned LEN_W           = 5;
    localparam int unsigned CODE_W          = 24;
    localparam logic [SYM_W-1:0] END_SYM_RST = 7'd26;

    localparam logic [1:0] KIND_GEN   = 2'd0;
    localparam logic [1:0] KIND_CTX   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_BIT   = 2'd3;

    typedef enum logic [7:0] {
        S_CLR   = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_CNT   = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_WAIT  = 8'b00010000,
        S_CMP   = 8'b00100000,
        S_DONE  = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;
endpackage

[rtl/core/chd_table_mem.sv]
// Table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module chd_table_mem
    import chd_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/context_huffman_decoder.sv]
// Top level: context-adaptive Huffman decoder with table loading and bit-serial decode.
`timescale 1ns / 1ps
// Each item is searched entry by entry over one shared compare unit reading the
// read port of the selected table memory (load items scan the target
// table for a duplicate codeword, code bits scan the selected context or generic
// table, stopping at the first hit); each compare passes through S_WAIT and then
// S_CMP behind the registered table read. Start items, bits while idle and
// rejected loads skip the search. A result waits in an output register; the block
// takes no new item until the running one has finished and its result has been
// taken. After reset a clearing pass zeroes all CONTEXTS context counts, with
// ready low.
module context_huffman_decoder
    import chd_pkg::*;
#(
    parameter int unsigned MAX_LEN     = MAX_LEN_DEF,
    parameter int unsigned GEN_ENTRIES = GEN_ENTRIES_DEF,
    parameter int unsigned CONTEXTS    = CONTEXTS_DEF,
    parameter int unsigned CTX_ENTRIES = CTX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SYM_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [SYM_W-1:0]  i_context_req,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [LEN_W-1:0]  i_code_length,
    input  logic [CODE_W-1:0] i_codeword,
    input  logic              i_bit_req,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SYM_W-1:0]  o_symbol_out,
    output logic              o_end_of_stream,
    output logic              o_no_match_error
);
    localparam int unsigned GA_W  = $clog2(GEN_ENTRIES);
    localparam int unsigned CE_W  = $clog2(CTX_ENTRIES) > 0 ? $clog2(CTX_ENTRIES) : 1;
    localparam int unsigned CX_W  = $clog2(CONTEXTS);
    localparam int unsigned CA_W  = $clog2(CONTEXTS * CTX_ENTRIES);
    localparam int unsigned GC_W  = $clog2(GEN_ENTRIES + 1);
    localparam int unsigned CC_W  = $clog2(CTX_ENTRIES + 1);
    localparam int unsigned IX_W  = GC_W > CC_W ? GC_W : CC_W;
    localparam int unsigned BUF_W = MAX_LEN;
    localparam int unsigned BL_W  = $clog2(MAX_LEN + 1);

    t_state r_state, n_state;
    logic [SYM_W-1:0]  r_end_sym;
    logic [GC_W-1:0]   r_gcount;
    logic [CC_W-1:0]   r_ccount [CONTEXTS];
    logic [CC_W-1:0]   r_ccount_rd;
    logic [CX_W-1:0]   r_clr;
    logic [SYM_W-1:0]  r_prev;
    logic [BUF_W-1:0]  r_buf;
    logic [BL_W-1:0]   r_blen;
    logic              r_active;
    logic [1:0]        r_kind;
    logic              r_use_ctx;
    logic [CX_W-1:0]   r_ctx;
    logic [SYM_W-1:0]  r_sym;
    logic [LEN_W-1:0]  r_len;
    logic [CODE_W-1:0] r_code;
    logic [IX_W-1:0]   r_idx;
    logic [IX_W-1:0]   r_cnt;
    logic              r_hit;
    logic [SYM_W-1:0]  r_hit_sym;
    logic              r_ovalid;
    logic [SYM_W-1:0]  r_osym;
    logic              r_oeos;
    logic              r_oerr;

    t_entry            w_gen_rd, w_ctx_rd, w_rd, w_wdata;
    logic              w_gen_we, w_ctx_we;
    logic [CA_W-1:0]   w_ctx_raddr, w_ctx_waddr;
    logic              w_match;
    logic [BUF_W-1:0]  w_nbuf;
    logic [CODE_W-1:0] w_mcode;
    logic [BUF_W:0]    w_lmask;
    logic              w_len_ok, w_ctx_ok;
    logic              w_cnt_we;
    logic [CX_W-1:0]   w_cnt_waddr, w_cnt_raddr;
    logic [CC_W-1:0]   w_cnt_wdata;

    assign w_lmask  = ({{BUF_W{1'b0}}, 1'b1} << i_code_length) - 1'b1;
    assign w_mcode  = i_codeword & CODE_W'(w_lmask[BUF_W-1:0]);
    assign w_len_ok = (i_code_length != '0) && (32'(i_code_length) <= MAX_LEN);
    assign w_ctx_ok = 32'(i_context_req) < CONTEXTS;
    assign w_nbuf   = (r_buf << 1) | BUF_W'(i_bit_req);

    assign w_ctx_raddr = CA_W'({r_ctx, CE_W'(r_idx)} >> (CE_W - $clog2(CTX_ENTRIES)));
    assign w_ctx_waddr = CA_W'({r_ctx, CE_W'(r_cnt)} >> (CE_W - $clog2(CTX_ENTRIES)));
    assign w_wdata  = '{sym: r_sym, len: r_len, code: r_code};
    assign w_gen_we = (r_state == S_DONE) && (r_kind == KIND_GEN) && !r_hit
                      && (32'(r_cnt) < GEN_ENTRIES);
    assign w_ctx_we = (r_state == S_DONE) && (r_kind == KIND_CTX) && !r_hit
                      && (32'(r_cnt) < CTX_ENTRIES);
    assign w_rd     = r_use_ctx ? w_ctx_rd : w_gen_rd;
    assign w_match  = (w_rd.len == r_len) && (w_rd.code == r_code);

    assign w_cnt_raddr = (i_kind == KIND_CTX) ? CX_W'(i_context_req) : CX_W'(r_prev);
    assign w_cnt_we    = (r_state == S_CLR) || w_ctx_we;
    assign w_cnt_waddr = (r_state == S_CLR) ? r_clr : r_ctx;
    assign w_cnt_wdata = (r_state == S_CLR) ? '0 : CC_W'(r_cnt + 1'b1);

    chd_table_mem #(.DEPTH(GEN_ENTRIES)) u_gen (
        .i_clk(i_clk), .i_we(w_gen_we), .i_waddr(GA_W'(r_cnt)), .i_wdata(w_wdata),
        .i_raddr(GA_W'(r_idx)), .o_rdata(w_gen_rd));

    chd_table_mem #(.DEPTH(CONTEXTS * CTX_ENTRIES)) u_ctx (
        .i_clk(i_clk), .i_we(w_ctx_we), .i_waddr(w_ctx_waddr), .i_wdata(w_wdata),
        .i_raddr(w_ctx_raddr), .o_rdata(w_ctx_rd));

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    // context entry counts
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_ccount[w_cnt_waddr] <= w_cnt_wdata;
        end
        r_ccount_rd <= r_ccount[w_cnt_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (32'(r_clr) == CONTEXTS - 1) n_state = S_IDLE;
            S_IDLE: if (i_valid && o_ready) n_state = S_CNT;
            S_CNT:  n_state = S_SCAN;
            S_SCAN: n_state = (r_idx < r_cnt) ? S_WAIT : S_DONE;
            S_WAIT: n_state = S_CMP;
            S_CMP:  n_state = (w_match || (r_idx + 1'b1 >= r_cnt)) ? S_DONE : S_WAIT;
            S_DONE: n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_end_sym <= END_SYM_RST;
            r_gcount <= '0;
            r_prev   <= '0;
            r_buf    <= '0;
            r_blen   <= '0;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_hit    <= 1'b0;
            r_kind   <= KIND_START;
            r_cnt    <= '0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_end_sym <= i_cfg_wdata;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_kind <= i_kind;
                        r_sym  <= i_symbol;
                        r_hit  <= 1'b0;
                        r_idx  <= '0;
                        r_cnt  <= '0;
                        r_ctx  <= w_cnt_raddr;
                        r_use_ctx <= 1'b0;
                        r_len  <= i_code_length;
                        r_code <= w_mcode;
                        case (i_kind)
                            KIND_GEN: begin
                                if (!w_len_ok) r_kind <= KIND_START;
                            end
                            KIND_CTX: begin
                                r_use_ctx <= 1'b1;
                                if (!w_len_ok || !w_ctx_ok) r_kind <= KIND_START;
                            end
                            KIND_START: begin
                                r_prev   <= '0;
                                r_buf    <= '0;
                                r_blen   <= '0;
                                r_active <= 1'b1;
                            end
                            default: begin
                                r_len  <= LEN_W'(r_blen + 1'b1);
                                r_code <= CODE_W'(w_nbuf);
                                r_buf  <= w_nbuf;
                                r_blen <= r_blen + 1'b1;
                                if (!r_active) begin
                                    r_kind <= KIND_START;
                                end else if (r_prev != '0 && 32'(r_prev) < CONTEXTS) begin
                                    r_use_ctx <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_CNT: begin
                    case (r_kind)
                        KIND_GEN: r_cnt <= IX_W'(r_gcount);
                        KIND_CTX: r_cnt <= IX_W'(r_ccount_rd);
                        KIND_BIT: begin
                            if (r_use_ctx && r_ccount_rd != '0) begin
                                r_cnt <= IX_W'(r_ccount_rd);
                            end else begin
                                r_use_ctx <= 1'b0;
                                r_cnt <= IX_W'(r_gcount);
                            end
                        end
                        default: ;
                    endcase
                end
                S_CMP: begin
                    if (w_match) begin
                        r_hit <= 1'b1;
                        r_hit_sym <= w_rd.sym;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_DONE: begin
                    if (w_gen_we) r_gcount <= r_gcount + 1'b1;
                end
                S_OUT: begin
                    if (r_kind == KIND_BIT) begin
                        if (r_hit) begin
                            r_buf <= '0;
                            r_blen <= '0;
                            r_ovalid <= 1'b1;
                            r_oerr <= 1'b0;
                            if (r_hit_sym == r_end_sym) begin
                                r_active <= 1'b0;
                                r_oeos <= 1'b1;
                                r_osym <= '0;
                            end else begin
                                r_prev <= r_hit_sym;
                                r_oeos <= 1'b0;
                                r_osym <= r_hit_sym;
                            end
                        end else if (32'(r_blen) >= MAX_LEN) begin
                            r_buf <= '0;
                            r_blen <= '0;
                            r_active <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_oerr <= 1'b1;
                            r_oeos <= 1'b0;
                            r_osym <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_symbol_out     = r_osym;
    assign o_end_of_stream  = r_oeos;
    assign o_no_match_error = r_oerr;
endmodule
